// ===== rtl/core/ikht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ikht_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                status;
    logic signed [VALUE_W-1:0] found_value;
    logic [COUNT_W-1:0]        entry_count;
  } out_item_t;

  // One slot of the table as it is kept in memory.
  typedef struct packed {
    logic                      valid;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } slot_t;

endpackage

`default_nettype wire

// ===== rtl/core/ikht_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ikht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/int_key_hash_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload type        Transfer when
// -------   ---------  ------------------  ---------------------------
// in        input      ikht_pkg::in_item_t   in_valid and in_ready high
// out       output     ikht_pkg::out_item_t  out_valid and out_ready high
//
// Insert, lookup and remove read one way per cycle from the slot memory and
// then load their result in the finishing step (S_DONE). When NUM_BUCKETS
// is not a power of two, a reciprocal multiply (S_MOD) and a subtract (S_REM)
// find the bucket first. A clear writes every slot, one per cycle, and then
// loads its result. After reset the same sweep runs without a result, and
// in_ready stays low until the sweep ends. The block is ready again the cycle
// after a result is loaded, even while that result waits; a stalled output
// holds the block only when the next result is ready to be loaded.

module int_key_hash_table #(
  parameter int NUM_BUCKETS     = 16,
  parameter int WAYS_PER_BUCKET = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ikht_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ikht_pkg::out_item_t      out_data
);

  localparam int SLOTS = NUM_BUCKETS * WAYS_PER_BUCKET;
  localparam int AW    = $clog2(SLOTS);
  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int WW    = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
  localparam bit BUCKETS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
  localparam logic [WW-1:0] LAST_WAY  = WW'(WAYS_PER_BUCKET - 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  // Reciprocal of the bucket count, rounded up, scaled by 2^(31 + BW). For
  // any 31-bit magnitude the product shifted right by that amount is the
  // exact quotient, and the reciprocal fits in 32 bits.
  localparam int            RECIP_SHIFT = 31 + BW;
  localparam logic [63:0]   RECIP_WIDE  =
    ((64'd1 << RECIP_SHIFT) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS);
  localparam logic [31:0]   RECIP       = RECIP_WIDE[31:0];
  localparam logic [BW-1:0] NB_LO       = BW'(NUM_BUCKETS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_REM   = 3'd5;

  logic [2:0]                          state;
  ikht_pkg::in_item_t                  item;
  logic [30:0]                         mag_sh;
  logic [30:0]                         quot;
  logic [BW-1:0]                       rem;
  logic [WW-1:0]                       issue_way;
  logic                                issue_done;
  logic                                chk_pend;
  logic [WW-1:0]                       chk_way;
  logic                                hit_found;
  logic [WW-1:0]                       hit_way;
  logic signed [ikht_pkg::VALUE_W-1:0] hit_value;
  logic                                free_found;
  logic [WW-1:0]                       free_way;
  logic [AW-1:0]                       clr_addr;
  logic                                clr_reply;
  logic [ikht_pkg::COUNT_W-1:0]        count;
  logic [ikht_pkg::COUNT_W-1:0]        count_next;

  logic [30:0]         in_mag;
  logic [62:0]         quot_prod;
  logic [BW-1:0]       quot_lo;
  logic [BW-1:0]       rem_next;
  logic [AW-1:0]       base_addr;
  logic                done_go;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  ikht_pkg::slot_t     wr_slot;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  ikht_pkg::slot_t     rd_slot;
  logic [2:0]          res_status;
  logic signed [ikht_pkg::VALUE_W-1:0] res_found;

  ikht_ram #(
    .WIDTH($bits(ikht_pkg::slot_t)),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_slot),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_slot)
  );

  // Magnitude of the incoming key. The most negative key has no 31-bit
  // magnitude and is sent to bucket 0, which a zero magnitude gives.
  always_comb begin
    if (in_data.key == {1'b1, 31'b0}) begin
      in_mag = '0;
    end else if (in_data.key[31]) begin
      in_mag = 31'(-in_data.key);
    end else begin
      in_mag = in_data.key[30:0];
    end
  end

  // Remainder by the bucket count: S_MOD forms the quotient from the
  // reciprocal, then S_REM takes quotient times bucket count off the magnitude.
  // The remainder is below the bucket count, so only its low bits are formed.
  assign quot_prod = 63'(mag_sh) * 63'(RECIP);
  assign quot_lo   = quot[BW-1:0] * NB_LO;
  assign rem_next  = mag_sh[BW-1:0] - quot_lo;
  assign base_addr = AW'(rem) * AW'(WAYS_PER_BUCKET);
  assign in_ready  = (state == S_IDLE);
  assign done_go   = !out_valid || out_ready;

  // Memory ports and the result of the finishing step.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = clr_addr;
    wr_slot    = '0;
    rd_en      = 1'b0;
    rd_addr    = base_addr + AW'(issue_way);
    res_status = ikht_pkg::ST_NOT_FOUND;
    res_found  = '0;
    count_next = count;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_SCAN: begin
        rd_en = !issue_done;
      end
      S_DONE: begin
        case (item.command)
          ikht_pkg::CMD_INSERT: begin
            wr_slot.valid = 1'b1;
            wr_slot.key   = item.key;
            wr_slot.value = item.value;
            if (hit_found) begin
              wr_en      = done_go;
              wr_addr    = base_addr + AW'(hit_way);
              res_status = ikht_pkg::ST_UPDATED;
            end else if (free_found) begin
              wr_en      = done_go;
              wr_addr    = base_addr + AW'(free_way);
              res_status = ikht_pkg::ST_INSERTED;
              count_next = count + 1'b1;
            end else begin
              res_status = ikht_pkg::ST_FULL;
            end
          end
          ikht_pkg::CMD_LOOKUP: begin
            if (hit_found) begin
              res_status = ikht_pkg::ST_FOUND;
              res_found  = hit_value;
            end
          end
          ikht_pkg::CMD_REMOVE: begin
            if (hit_found) begin
              wr_en      = done_go;
              wr_addr    = base_addr + AW'(hit_way);
              res_status = ikht_pkg::ST_REMOVED;
              count_next = count - 1'b1;
            end
          end
          default: begin
            res_status = ikht_pkg::ST_CLEARED;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register empties on its transfer and may be refilled by
      // the finishing step in the same cycle.
      if (state == S_DONE && done_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item       <= in_data;
            mag_sh     <= in_mag;
            issue_way  <= '0;
            issue_done <= 1'b0;
            chk_pend   <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            if (in_data.command == ikht_pkg::CMD_CLEAR) begin
              clr_addr  <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end else if (BUCKETS_POW2) begin
              rem   <= in_mag[BW-1:0];
              state <= S_SCAN;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          quot  <= 31'(quot_prod >> RECIP_SHIFT);
          state <= S_REM;
        end
        S_REM: begin
          rem   <= rem_next;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // Reads are issued one way per cycle; the data of a way is checked
          // in the cycle after its read.
          chk_pend <= !issue_done;
          chk_way  <= issue_way;
          if (!issue_done) begin
            if (issue_way == LAST_WAY) begin
              issue_done <= 1'b1;
            end else begin
              issue_way <= issue_way + 1'b1;
            end
          end
          if (chk_pend) begin
            if (rd_slot.valid) begin
              if (!hit_found && rd_slot.key == item.key) begin
                hit_found <= 1'b1;
                hit_way   <= chk_way;
                hit_value <= rd_slot.value;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_way   <= chk_way;
            end
            if (chk_way == LAST_WAY) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (done_go) begin
            out_data.status      <= res_status;
            out_data.found_value <= res_found;
            out_data.entry_count <= count_next;
            count                <= count_next;
            state                <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SLOT) begin
            count <= '0;
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for int_key_hash_table. A behavioral copy of the table
// tracks every accepted command and queues the result it should produce; the
// result checker compares the block's output against that queue in order.
module tb;

  localparam int NUM_BUCKETS     = 16;
  localparam int WAYS_PER_BUCKET = 4;
  localparam int SLOT_COUNT      = NUM_BUCKETS * WAYS_PER_BUCKET;

  // The longest legal silence on both channels is the deliberate receiver
  // hold-off plus one clear sweep and some random stall. The limit sits well
  // above that.
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 2000;
  // A clear sweeps every slot, so it sets the tail we wait out after a drain.
  localparam int SETTLE_CYCLES  = SLOT_COUNT + 16;
  localparam int PHASE_COMMANDS = 450;
  localparam int HOT_KEYS       = 40;

  localparam logic signed [ikht_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [ikht_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ikht_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ikht_pkg::out_item_t out_data;

  int_key_hash_table #(
    .NUM_BUCKETS    (NUM_BUCKETS),
    .WAYS_PER_BUCKET(WAYS_PER_BUCKET)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the table. Slot s holds bucket s / WAYS_PER_BUCKET.
  logic signed [ikht_pkg::KEY_W-1:0]   shadow_keys   [SLOT_COUNT];
  logic signed [ikht_pkg::VALUE_W-1:0] shadow_values [SLOT_COUNT];
  bit                                  shadow_valid  [SLOT_COUNT];
  logic [ikht_pkg::COUNT_W-1:0]        shadow_count = '0;

  // Results owed by the block, oldest first.
  ikht_pkg::out_item_t awaited_results [$];

  int error_count     = 0;
  int commands_sent   = 0;
  int clears_sent     = 0;
  int results_checked = 0;
  int peak_count      = 0;
  int status_tally [8];
  int quiet_cycles    = 0;

  // Idle percentages for the current phase, and the long receiver hold-off.
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  logic receiver_hold      = 1'b0;

  // Keys packed into six buckets, so that hits, updates and full buckets are
  // common during random traffic.
  logic signed [ikht_pkg::KEY_W-1:0] hot_keys [HOT_KEYS];

  // Bucket of a key: its magnitude modulo the bucket count. The most negative
  // key has no positive magnitude in 32 bits and is pinned to bucket 0.
  function automatic int unsigned bucket_index(logic signed [ikht_pkg::KEY_W-1:0] k);
    logic [ikht_pkg::KEY_W-1:0] mag;
    if (k == KEY_MIN) return 0;
    mag = k[ikht_pkg::KEY_W-1] ? -k : k;
    return mag % NUM_BUCKETS;
  endfunction

  function automatic bit bucket_is_full(int unsigned b);
    for (int w = 0; w < WAYS_PER_BUCKET; w++)
      if (!shadow_valid[b * WAYS_PER_BUCKET + w]) return 1'b0;
    return 1'b1;
  endfunction

  // Applies one command to the shadow table and returns the result the block
  // must give for it. A hit takes priority over a free way; a new key takes
  // the lowest free way of its bucket.
  function automatic ikht_pkg::out_item_t apply_command(ikht_pkg::in_item_t item);
    ikht_pkg::out_item_t res;
    int unsigned         base;
    int                  hit;
    int                  free_slot;
    res        = '0;
    res.status = ikht_pkg::ST_NOT_FOUND;
    hit        = -1;
    free_slot  = -1;
    if (item.command == ikht_pkg::CMD_CLEAR) begin
      foreach (shadow_valid[s]) shadow_valid[s] = 1'b0;
      shadow_count = '0;
      res.status   = ikht_pkg::ST_CLEARED;
    end else begin
      base = bucket_index(item.key) * WAYS_PER_BUCKET;
      for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
        if (shadow_valid[base + w]) begin
          if (hit < 0 && shadow_keys[base + w] == item.key) hit = base + w;
        end else if (free_slot < 0) begin
          free_slot = base + w;
        end
      end
      case (item.command)
        ikht_pkg::CMD_INSERT: begin
          if (hit >= 0) begin
            shadow_values[hit] = item.value;
            res.status = ikht_pkg::ST_UPDATED;
          end else if (free_slot >= 0) begin
            shadow_keys[free_slot]   = item.key;
            shadow_values[free_slot] = item.value;
            shadow_valid[free_slot]  = 1'b1;
            shadow_count = shadow_count + 1'b1;
            res.status = ikht_pkg::ST_INSERTED;
          end else begin
            res.status = ikht_pkg::ST_FULL;
          end
        end
        ikht_pkg::CMD_LOOKUP: begin
          if (hit >= 0) begin
            res.found_value = shadow_values[hit];
            res.status = ikht_pkg::ST_FOUND;
          end
        end
        default: begin
          if (hit >= 0) begin
            shadow_valid[hit] = 1'b0;
            shadow_count = shadow_count - 1'b1;
            res.status = ikht_pkg::ST_REMOVED;
          end
        end
      endcase
    end
    res.entry_count = shadow_count;
    return res;
  endfunction

  // A random key whose magnitude lands in bucket b, with a random sign.
  function automatic logic signed [ikht_pkg::KEY_W-1:0] key_in_bucket(int unsigned b);
    logic signed [ikht_pkg::KEY_W-1:0] mag;
    mag = b + NUM_BUCKETS * $urandom_range(1 << 20);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  function automatic logic signed [ikht_pkg::KEY_W-1:0] corner_word();
    case ($urandom_range(3))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Offers one command, after a random idle gap, and waits for its transfer.
  // Valid stays high afterwards; the next call or a drain decides its fate,
  // so it is never lowered and raised in the same step.
  task automatic send_command(input logic [1:0] cmd,
                              input logic signed [ikht_pkg::KEY_W-1:0] key,
                              input logic signed [ikht_pkg::VALUE_W-1:0] value);
    ikht_pkg::in_item_t item;
    item.command = cmd;
    item.key     = key;
    item.value   = value;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_results.push_back(apply_command(item));
    commands_sent++;
    if (cmd == ikht_pkg::CMD_CLEAR) clears_sent++;
  endtask

  // Mostly hot keys, with inserts the most common command, enough removes to
  // keep buckets turning over, and a rare clear.
  task automatic send_random_command();
    int unsigned                         pick;
    logic [1:0]                          cmd;
    logic signed [ikht_pkg::KEY_W-1:0]   key;
    logic signed [ikht_pkg::VALUE_W-1:0] value;
    pick = $urandom_range(199);
    if (pick < 2) cmd = ikht_pkg::CMD_CLEAR;
    else if (pick < 80) cmd = ikht_pkg::CMD_INSERT;
    else if (pick < 140) cmd = ikht_pkg::CMD_LOOKUP;
    else cmd = ikht_pkg::CMD_REMOVE;
    pick = $urandom_range(99);
    if (pick < 60) key = hot_keys[$urandom_range(HOT_KEYS - 1)];
    else if (pick < 85) key = key_in_bucket($urandom_range(NUM_BUCKETS - 1));
    else if (pick < 95) key = $urandom;
    else key = corner_word();
    value = ($urandom_range(9) == 0) ? corner_word() : $urandom;
    send_command(cmd, key, value);
  endtask

  // Stops offering, waits until every owed result has arrived, then waits out
  // the given tail so that any stray result shows up.
  task automatic wait_for_results(int unsigned tail);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Empty-table misses, the most negative key sharing bucket 0, a full
  // bucket, update in place, reuse of a freed way, and clear.
  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_command(ikht_pkg::CMD_LOOKUP, 0, -1);
    send_command(ikht_pkg::CMD_REMOVE, KEY_MIN, 0);
    send_command(ikht_pkg::CMD_INSERT, 0, KEY_MAX);
    send_command(ikht_pkg::CMD_INSERT, KEY_MIN, KEY_MIN);
    send_command(ikht_pkg::CMD_INSERT, 16, -1);
    send_command(ikht_pkg::CMD_INSERT, -16, 7);
    // Bucket 0 now holds four keys, so this one is refused.
    send_command(ikht_pkg::CMD_INSERT, 32, 1);
    send_command(ikht_pkg::CMD_INSERT, 0, 5);
    send_command(ikht_pkg::CMD_LOOKUP, KEY_MIN, 0);
    send_command(ikht_pkg::CMD_LOOKUP, 0, KEY_MIN);
    send_command(ikht_pkg::CMD_LOOKUP, 32, 0);
    send_command(ikht_pkg::CMD_REMOVE, 16, 0);
    send_command(ikht_pkg::CMD_INSERT, 32, 32'sh5A5A_5A5A);
    send_command(ikht_pkg::CMD_LOOKUP, 32, 0);
    send_command(ikht_pkg::CMD_REMOVE, 16, 0);
    send_command(ikht_pkg::CMD_INSERT, KEY_MAX, 0);
    send_command(ikht_pkg::CMD_INSERT, -1, KEY_MAX);
    // Key 1 shares a bucket with -1 but must not match it.
    send_command(ikht_pkg::CMD_LOOKUP, 1, 0);
    send_command(ikht_pkg::CMD_LOOKUP, -1, 0);
    send_command(ikht_pkg::CMD_CLEAR, KEY_MAX, KEY_MIN);
    send_command(ikht_pkg::CMD_LOOKUP, KEY_MAX, 0);
    send_command(ikht_pkg::CMD_CLEAR, 0, 0);
    send_command(ikht_pkg::CMD_INSERT, -2, 3);
    send_command(ikht_pkg::CMD_REMOVE, -2, 0);
    wait_for_results(SETTLE_CYCLES);
  endtask

  // Fills every bucket so the count reaches SLOT_COUNT, overflows one bucket,
  // then reads back and removes a random half of the live keys.
  task automatic test_fill_table();
    sender_idle_pct    = 30;
    receiver_stall_pct = 30;
    for (int b = 0; b < NUM_BUCKETS; b++)
      while (!bucket_is_full(b))
        send_command(ikht_pkg::CMD_INSERT, key_in_bucket(b), $urandom);
    send_command(ikht_pkg::CMD_INSERT, key_in_bucket($urandom_range(NUM_BUCKETS - 1)),
                 $urandom);
    for (int s = 0; s < SLOT_COUNT; s++)
      if (shadow_valid[s] && $urandom_range(1))
        send_command(ikht_pkg::CMD_LOOKUP, shadow_keys[s], $urandom);
    for (int s = 0; s < SLOT_COUNT; s++)
      if (shadow_valid[s] && $urandom_range(1))
        send_command(ikht_pkg::CMD_REMOVE, shadow_keys[s], $urandom);
    wait_for_results(SETTLE_CYCLES);
  endtask

  // The receiver holds off for a long stretch while commands keep coming,
  // so the output register fills and the block has to stall its input.
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    fork
      begin
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold <= 1'b0;
      end
      repeat (40) send_random_command();
    join
    wait_for_results(SETTLE_CYCLES);
  endtask

  task automatic test_random_traffic(int sender_pct, int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    repeat (PHASE_COMMANDS) send_random_command();
    wait_for_results(SETTLE_CYCLES);
  endtask

  // Receiver ready. All reads at the edge see values from before it, since
  // every bench signal and the block's registers change by nonblocking update.
  always @(posedge clk) begin
    out_ready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Result checker: each output transfer is matched to the oldest owed result.
  always @(posedge clk) begin : check_results
    ikht_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("Result with no command outstanding: status %0d", out_data.status);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.found_value !== want.found_value) begin
          $error("found_value: expected %0d, got %0d", want.found_value,
                 out_data.found_value);
          error_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_data.entry_count);
          error_count++;
        end
        results_checked++;
        status_tally[want.status]++;
        if (want.entry_count > peak_count) peak_count = want.entry_count;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results still owed",
               quiet_cycles, awaited_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < HOT_KEYS; i++) hot_keys[i] = key_in_bucket((i % 6) * 3);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_table();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(77, 0);
    test_random_traffic(0, 77);
    test_random_traffic(20, 20);

    $display("Sent %0d commands (%0d clears), checked %0d results, peak count %0d.",
             commands_sent, clears_sent, results_checked, peak_count);
    $display("Results by status: ins %0d upd %0d found %0d miss %0d",
             status_tally[ikht_pkg::ST_INSERTED], status_tally[ikht_pkg::ST_UPDATED],
             status_tally[ikht_pkg::ST_FOUND], status_tally[ikht_pkg::ST_NOT_FOUND]);
    $display("  rem %0d full %0d clr %0d",
             status_tally[ikht_pkg::ST_REMOVED], status_tally[ikht_pkg::ST_FULL],
             status_tally[ikht_pkg::ST_CLEARED]);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
